@@ sv/wrp_pkg.sv @@
// shared types and constants for the weighted reservoir picker
// used by the front parser, the operation queue, the back end and the top level
`default_nettype none

package wrp_pkg;

  localparam int WEIGHT_BITS = 24;
  localparam int TOTAL_BITS  = 32;
  localparam int CHAR_BITS   = 8;
  localparam int RND_BITS    = 31;
  localparam int CNT_BITS    = $clog2(RND_BITS);

  localparam logic [CHAR_BITS-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_Z     = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam int                   DEC_BASE = 10;

  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX  = {TOTAL_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_AFTER,
    PH_WEIGHT,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // one operation handed from the parser to the back end
  typedef struct packed {
    logic                   close;
    logic                   emit;
    logic [WEIGHT_BITS-1:0] weight;
    logic [CHAR_BITS-1:0]   first;
    logic [CHAR_BITS-1:0]   second;
    logic [RND_BITS-1:0]    rnd;
  } op_t;

endpackage

`default_nettype wire

@@ sv/wrp_front.sv @@
// front parser: walks the list byte by byte and turns entry ends into operations
// depends on wrp_pkg
`default_nettype none

module wrp_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       byte_vld,
  input  wire  [wrp_pkg::CHAR_BITS-1:0] text_byte,
  input  wire  [wrp_pkg::RND_BITS-1:0]  random_word,
  input  wire                       last,
  output logic                      op_push,
  output wrp_pkg::op_t              op_data
);
  import wrp_pkg::*;

  localparam int ACC_BITS = WEIGHT_BITS + 5;

  phase_t                 phase_r, phase_nxt;
  logic [CHAR_BITS-1:0]   first_r, first_nxt;
  logic [CHAR_BITS-1:0]   second_r, second_nxt;
  logic [WEIGHT_BITS-1:0] weight_r, weight_nxt;
  logic                   is_cap, is_digit;
  logic [ACC_BITS-1:0]    acc;
  logic                   close_now;
  logic [WEIGHT_BITS-1:0] close_w;

  assign is_cap   = (text_byte >= CH_A) && (text_byte <= CH_Z);
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign acc      = ACC_BITS'(weight_r) * ACC_BITS'(DEC_BASE)
                  + ACC_BITS'(text_byte - CH_ZERO);

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    weight_nxt = weight_r;
    close_now  = 1'b0;
    close_w    = weight_r;
    unique case (phase_r)
      PH_FIRST: begin
        if (is_cap) begin
          first_nxt = text_byte;
          phase_nxt = PH_SECOND;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      PH_SECOND: begin
        if (is_cap) begin
          second_nxt = text_byte;
          phase_nxt  = PH_AFTER;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
      PH_AFTER: begin
        if (text_byte == CH_COLON) begin
          weight_nxt = '0;
          phase_nxt  = PH_WEIGHT;
        end else begin
          close_now = 1'b1;
          close_w   = WEIGHT_BITS'(1);
          phase_nxt = (text_byte == CH_COMMA) ? PH_FIRST : PH_STOP;
        end
      end
      PH_WEIGHT: begin
        if (is_digit) begin
          weight_nxt = (acc > ACC_BITS'(WEIGHT_MAX)) ? WEIGHT_MAX : acc[WEIGHT_BITS-1:0];
        end else begin
          close_now = 1'b1;
          phase_nxt = (text_byte == CH_COMMA) ? PH_FIRST : PH_STOP;
        end
      end
      default: phase_nxt = PH_STOP;
    endcase

    // end of list closes an open entry with the same draw
    if (last && (phase_nxt == PH_AFTER)) begin
      close_now = 1'b1;
      close_w   = WEIGHT_BITS'(1);
    end else if (last && (phase_nxt == PH_WEIGHT)) begin
      close_now = 1'b1;
      close_w   = weight_nxt;
    end

    op_push        = byte_vld && (close_now || last);
    op_data.close  = close_now;
    op_data.emit   = last;
    op_data.weight = close_w;
    op_data.first  = first_nxt;
    op_data.second = second_nxt;
    op_data.rnd    = random_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      first_r  <= '0;
      second_r <= '0;
      weight_r <= '0;
    end else if (byte_vld) begin
      if (last) begin
        phase_r  <= PH_FIRST;
        first_r  <= '0;
        second_r <= '0;
        weight_r <= '0;
      end else begin
        phase_r  <= phase_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        weight_r <= weight_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/wrp_queue.sv @@
// two-entry operation queue between the parser and the back end
// depends on wrp_pkg
`default_nettype none

module wrp_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  wrp_pkg::op_t  push_data,
  output logic          full,
  input  wire           pop,
  output wrp_pkg::op_t  pop_data,
  output logic          empty
);
  import wrp_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/wrp_back.sv @@
// back end: total update, bit-serial modulo of the draw, pick update and result register
// depends on wrp_pkg
`default_nettype none

module wrp_back (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            op_avail,
  input  wrp_pkg::op_t                   op_data,
  output logic                           op_pop,
  output logic                           res_valid,
  input  wire                            res_ready,
  output logic                           res_picked,
  output logic [wrp_pkg::CHAR_BITS-1:0]  res_first,
  output logic [wrp_pkg::CHAR_BITS-1:0]  res_second,
  output logic [wrp_pkg::TOTAL_BITS-1:0] res_total
);
  import wrp_pkg::*;

  back_state_t           st_r, st_nxt;
  op_t                   op_r, op_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [CHAR_BITS-1:0]  kfirst_r, kfirst_nxt;
  logic [CHAR_BITS-1:0]  ksecond_r, ksecond_nxt;
  logic                  have_r, have_nxt;
  logic [TOTAL_BITS-1:0] rem_r, rem_nxt;
  logic [RND_BITS-1:0]   rnd_r, rnd_nxt;
  logic [CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                  div_r, div_nxt;
  logic                  ovld_r, ovld_nxt;
  logic                  opick_r, opick_nxt;
  logic [CHAR_BITS-1:0]  ofirst_r, ofirst_nxt;
  logic [CHAR_BITS-1:0]  osecond_r, osecond_nxt;
  logic [TOTAL_BITS-1:0] ototal_r, ototal_nxt;
  logic [TOTAL_BITS:0]   sum, shifted, diff;
  logic                  hit, out_free;

  assign sum      = {1'b0, total_r} + (TOTAL_BITS+1)'(op_data.weight);
  assign shifted  = {rem_r, rnd_r[RND_BITS-1]};
  assign diff     = shifted - {1'b0, total_r};
  assign hit      = div_r && (rem_r < TOTAL_BITS'(op_r.weight));
  assign out_free = !ovld_r || res_ready;

  always_comb begin
    st_nxt      = st_r;
    op_nxt      = op_r;
    total_nxt   = total_r;
    kfirst_nxt  = kfirst_r;
    ksecond_nxt = ksecond_r;
    have_nxt    = have_r;
    rem_nxt     = rem_r;
    rnd_nxt     = rnd_r;
    cnt_nxt     = cnt_r;
    div_nxt     = div_r;
    ovld_nxt    = ovld_r && !res_ready;
    opick_nxt   = opick_r;
    ofirst_nxt  = ofirst_r;
    osecond_nxt = osecond_r;
    ototal_nxt  = ototal_r;
    op_pop      = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (op_avail) begin
          op_pop  = 1'b1;
          op_nxt  = op_data;
          rem_nxt = '0;
          rnd_nxt = op_data.rnd;
          cnt_nxt = '0;
          if (op_data.close && (op_data.weight != '0)) begin
            total_nxt = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
            div_nxt   = 1'b1;
            st_nxt    = BK_DIV;
          end else begin
            div_nxt = 1'b0;
            st_nxt  = BK_DONE;
          end
        end
      end
      BK_DIV: begin
        // restoring division, one remainder bit per cycle
        rem_nxt = (shifted >= {1'b0, total_r}) ? diff[TOTAL_BITS-1:0]
                                               : shifted[TOTAL_BITS-1:0];
        rnd_nxt = {rnd_r[RND_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(RND_BITS - 1)) begin
          st_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (hit) begin
          kfirst_nxt  = op_r.first;
          ksecond_nxt = op_r.second;
          have_nxt    = 1'b1;
        end
        if (!op_r.emit) begin
          st_nxt = BK_IDLE;
        end else if (out_free) begin
          ovld_nxt    = 1'b1;
          opick_nxt   = have_nxt;
          ofirst_nxt  = kfirst_nxt;
          osecond_nxt = ksecond_nxt;
          ototal_nxt  = total_r;
          total_nxt   = '0;
          kfirst_nxt  = '0;
          ksecond_nxt = '0;
          have_nxt    = 1'b0;
          st_nxt      = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      total_r   <= '0;
      kfirst_r  <= '0;
      ksecond_r <= '0;
      have_r    <= 1'b0;
      ovld_r    <= 1'b0;
      div_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      total_r   <= total_nxt;
      kfirst_r  <= kfirst_nxt;
      ksecond_r <= ksecond_nxt;
      have_r    <= have_nxt;
      ovld_r    <= ovld_nxt;
      div_r     <= div_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    rem_r     <= rem_nxt;
    rnd_r     <= rnd_nxt;
    opick_r   <= opick_nxt;
    ofirst_r  <= ofirst_nxt;
    osecond_r <= osecond_nxt;
    ototal_r  <= ototal_nxt;
  end

  assign res_valid  = ovld_r;
  assign res_picked = opick_r;
  assign res_first  = ofirst_r;
  assign res_second = osecond_r;
  assign res_total  = ototal_r;

endmodule

`default_nettype wire

@@ sv/weighted_reservoir_picker.sv @@
// top level of the weighted reservoir picker: stream ports around parser, queue and back end
// depends on wrp_pkg, wrp_front, wrp_queue, wrp_back
`default_nettype none

// Picks one two-letter code from a list "CC:weight,CC:weight,..." streamed one
// byte per transfer, each byte carrying a 31-bit random draw. A missing weight
// counts as 1, weight 0 skips the entry, weights saturate at 24 bits and the
// total at 32 bits. Parsing stops at the first malformed pair or at any byte
// other than a comma after an entry. One result transfer follows the byte
// marked by in_tlast: picked flag, the two letters (zero if none) and the total,
// after which all state starts afresh. A byte that closes an entry with nonzero
// weight holds the back end for the bit-serial modulo of the draw by the running
// total, one remainder bit per cycle; the parser keeps taking bytes until the
// two-entry queue in front of the back end fills. The result sits in an output
// register, so the back end moves on while it waits to be taken, and stalls
// only when it has a further result to hand over before then.
module weighted_reservoir_picker (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // text_byte [7:0], random_word [38:8], zero [39]
  input  wire         in_tlast,   // last byte of the list
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [47:0] out_tdata,  // first_letter [7:0], second_letter [15:8],
                                  // weight_total [47:16]
  output logic        out_tuser   // picked
);
  import wrp_pkg::*;

  logic                  q_full, q_empty, q_push, q_pop;
  op_t                   q_in, q_out;
  logic                  byte_vld;
  logic                  res_picked;
  logic [CHAR_BITS-1:0]  res_first, res_second;
  logic [TOTAL_BITS-1:0] res_total;

  // a byte is only taken when its operation surely fits in the queue
  assign in_tready = !q_full;
  assign byte_vld  = in_tvalid && in_tready;

  wrp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_vld    (byte_vld),
    .text_byte   (in_tdata[CHAR_BITS-1:0]),
    .random_word (in_tdata[CHAR_BITS +: RND_BITS]),
    .last        (in_tlast),
    .op_push     (q_push),
    .op_data     (q_in)
  );

  wrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  wrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_avail   (!q_empty),
    .op_data    (q_out),
    .op_pop     (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_picked (res_picked),
    .res_first  (res_first),
    .res_second (res_second),
    .res_total  (res_total)
  );

  assign out_tdata = {res_total, res_second, res_first};
  assign out_tuser = res_picked;

endmodule

`default_nettype wire
